>>> rtl/psd_pkg.sv
`default_nettype none

package psd_pkg;

  // coordinate and intermediate widths
  localparam int unsigned CoordW    = 32;
  localparam int unsigned DiffW     = CoordW + 1;
  localparam int unsigned SqW       = 2 * DiffW;
  localparam int unsigned DotW      = SqW + 2;
  localparam int unsigned NumW      = 2 * SqW;
  localparam int unsigned DistW     = 33;
  localparam int unsigned DivSteps  = SqW;
  localparam int unsigned SqrtSteps = SqW / 2;
  localparam int unsigned RemW      = DistW + 3;

  // which part of the segment is nearest
  typedef enum logic [1:0] {
    CASE_DEGENERATE = 2'd0,
    CASE_START      = 2'd1,
    CASE_END        = 2'd2,
    CASE_INTERIOR   = 2'd3
  } case_e;

endpackage

`default_nettype wire

>>> rtl/point_segment_distance.sv
`default_nettype none

// Distance from a 3d query point to a segment, all coordinates signed Q16.16.
// Input channel: in_valid_i / in_ready_o carry one query beat (point, start,
// end). Output channel: out_valid_o / out_ready_i carry one result beat: the
// distance as unsigned Q17.16 rounded down, and a code for the nearest part
// (degenerate segment, start, end or interior).
// Throughput: one query per cycle while the output side takes results.
// Pipeline stages from acceptance to out_valid_o: 5 front stages (deltas,
// products, sums, classify with the squared dot product, numerator sum), 66
// restoring divider stages (one quotient bit each), one radicand stage and 33
// square root stages (one root bit each), the last being the output register.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready_o drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; no result is shown until a query passes through.

module point_segment_distance
  import psd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output      logic                     in_ready_o,
  input  wire logic signed [CoordW-1:0] point_x_i,
  input  wire logic signed [CoordW-1:0] point_y_i,
  input  wire logic signed [CoordW-1:0] point_z_i,
  input  wire logic signed [CoordW-1:0] start_x_i,
  input  wire logic signed [CoordW-1:0] start_y_i,
  input  wire logic signed [CoordW-1:0] start_z_i,
  input  wire logic signed [CoordW-1:0] end_x_i,
  input  wire logic signed [CoordW-1:0] end_y_i,
  input  wire logic signed [CoordW-1:0] end_z_i,
  output      logic                     out_valid_o,
  input  wire logic                     out_ready_i,
  output      logic [DistW-1:0]         distance_o,
  output      logic [1:0]               nearest_case_o
);

  logic en;

  // input coordinates as vectors
  logic signed [CoordW-1:0] pt [3];
  logic signed [CoordW-1:0] st [3];
  logic signed [CoordW-1:0] ed [3];

  always_comb begin
    pt[0] = point_x_i; pt[1] = point_y_i; pt[2] = point_z_i;
    st[0] = start_x_i; st[1] = start_y_i; st[2] = start_z_i;
    ed[0] = end_x_i;   ed[1] = end_y_i;   ed[2] = end_z_i;
  end

  // stage 1: differences
  logic                    v1_q;
  logic signed [DiffW-1:0] to_q  [3];
  logic signed [DiffW-1:0] dir_q [3];
  logic signed [DiffW-1:0] fe_q  [3];

  // stage 2: products
  logic                  v2_q;
  logic signed [SqW-1:0] ll_q [3];
  logic signed [SqW-1:0] aa_q [3];
  logic signed [SqW-1:0] td_q [3];
  logic signed [SqW-1:0] bb_q [3];

  // stage 3: dot products
  logic                   v3_q;
  logic [SqW-1:0]         len2_q;
  logic [SqW-1:0]         a2_q;
  logic [SqW-1:0]         b2_q;
  logic signed [DotW-1:0] dot_q;

  // stage 4: classify and partial products of dot squared
  logic           v4_q;
  case_e          kind4_q;
  logic [SqW-1:0] len4_q;
  logic [SqW-1:0] a4_q;
  logic [SqW-1:0] rad4_q;
  logic [SqW-1:0] phh_q;
  logic [SqW-1:0] phl_q;
  logic [SqW-1:0] pll_q;
  case_e          kind_d;
  logic [DiffW-1:0] dot_hi;
  logic [DiffW-1:0] dot_lo;

  // divider stages, index 0 is the numerator stage
  logic           d_v    [DivSteps+1];
  case_e          d_kind [DivSteps+1];
  logic [SqW-1:0] d_len  [DivSteps+1];
  logic [SqW-1:0] d_a2   [DivSteps+1];
  logic [SqW-1:0] d_rad  [DivSteps+1];
  logic [SqW-1:0] d_rem  [DivSteps+1];
  logic [SqW-1:0] d_low  [DivSteps+1];
  logic [SqW-1:0] d_quo  [DivSteps+1];
  logic [NumW-1:0] num;

  // square root stages, index 0 is the radicand stage
  logic             s_v    [SqrtSteps+1];
  case_e            s_kind [SqrtSteps+1];
  logic [SqW-1:0]   s_rad  [SqrtSteps+1];
  logic [RemW-1:0]  s_rem  [SqrtSteps+1];
  logic [DistW-1:0] s_root [SqrtSteps+1];
  logic [SqW:0]     rad_int;

  // whole pipeline advances unless a result waits
  assign en         = out_ready_i || !out_valid_o;
  assign in_ready_o = en;

  // front valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      d_v[0] <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      d_v[0] <= v4_q;
    end
  end

  // differences and products
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        to_q[i]  <= DiffW'(pt[i]) - DiffW'(st[i]);
        dir_q[i] <= DiffW'(ed[i]) - DiffW'(st[i]);
        fe_q[i]  <= DiffW'(pt[i]) - DiffW'(ed[i]);
        ll_q[i]  <= SqW'(dir_q[i]) * SqW'(dir_q[i]);
        aa_q[i]  <= SqW'(to_q[i]) * SqW'(to_q[i]);
        td_q[i]  <= SqW'(to_q[i]) * SqW'(dir_q[i]);
        bb_q[i]  <= SqW'(fe_q[i]) * SqW'(fe_q[i]);
      end
    end
  end

  // sums of products
  always_ff @(posedge clk_i) begin
    if (en) begin
      len2_q <= SqW'(ll_q[0]) + SqW'(ll_q[1]) + SqW'(ll_q[2]);
      a2_q   <= SqW'(aa_q[0]) + SqW'(aa_q[1]) + SqW'(aa_q[2]);
      b2_q   <= SqW'(bb_q[0]) + SqW'(bb_q[1]) + SqW'(bb_q[2]);
      dot_q  <= DotW'(td_q[0]) + DotW'(td_q[1]) + DotW'(td_q[2]);
    end
  end

  // classify the query
  always_comb begin
    if (len2_q == '0) begin
      kind_d = CASE_DEGENERATE;
    end else if (dot_q < 0) begin
      kind_d = CASE_START;
    end else if (dot_q > $signed({2'b00, len2_q})) begin
      kind_d = CASE_END;
    end else begin
      kind_d = CASE_INTERIOR;
    end
  end

  assign dot_hi = dot_q[SqW-1:DiffW];
  assign dot_lo = dot_q[DiffW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind4_q <= kind_d;
      len4_q  <= len2_q;
      a4_q    <= a2_q;
      rad4_q  <= (kind_d == CASE_END) ? b2_q : a2_q;
      phh_q   <= SqW'(dot_hi) * SqW'(dot_hi);
      phl_q   <= SqW'(dot_hi) * SqW'(dot_lo);
      pll_q   <= SqW'(dot_lo) * SqW'(dot_lo);
    end
  end

  // dot squared, split into remainder seed and low bits
  assign num = {phh_q, {SqW{1'b0}}} + {{(DiffW-1){1'b0}}, phl_q, {(DiffW+1){1'b0}}}
             + {{SqW{1'b0}}, pll_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_kind[0] <= kind4_q;
      d_len[0]  <= len4_q;
      d_a2[0]   <= a4_q;
      d_rad[0]  <= rad4_q;
      d_rem[0]  <= num[NumW-1:SqW];
      d_low[0]  <= num[SqW-1:0];
      d_quo[0]  <= '0;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 1; k <= DivSteps; k++) begin : g_div
    logic [SqW:0] trial;
    logic         ge;

    assign trial = {d_rem[k-1], d_low[k-1][SqW-1]};
    assign ge    = trial >= {1'b0, d_len[k-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_v[k] <= 1'b0;
      end else if (en) begin
        d_v[k] <= d_v[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        d_kind[k] <= d_kind[k-1];
        d_len[k]  <= d_len[k-1];
        d_a2[k]   <= d_a2[k-1];
        d_rad[k]  <= d_rad[k-1];
        d_rem[k]  <= ge ? SqW'(trial - {1'b0, d_len[k-1]}) : trial[SqW-1:0];
        d_low[k]  <= {d_low[k-1][SqW-2:0], 1'b0};
        d_quo[k]  <= {d_quo[k-1][SqW-2:0], ge};
      end
    end
  end

  // interior radicand: a2 minus the ceiling of dot squared over len2
  assign rad_int = {1'b0, d_a2[DivSteps]} - {1'b0, d_quo[DivSteps]}
                 - {{SqW{1'b0}}, (d_rem[DivSteps] != '0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v[0] <= 1'b0;
    end else if (en) begin
      s_v[0] <= d_v[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_kind[0] <= d_kind[DivSteps];
      s_rad[0]  <= (d_kind[DivSteps] == CASE_INTERIOR) ? rad_int[SqW-1:0] : d_rad[DivSteps];
      s_rem[0]  <= '0;
      s_root[0] <= '0;
    end
  end

  // digit-by-digit square root, one root bit per stage
  for (genvar k = 1; k <= SqrtSteps; k++) begin : g_sqrt
    logic [RemW-1:0] cur;
    logic [RemW-1:0] trial;
    logic            ge;

    assign cur   = {s_rem[k-1][RemW-3:0], s_rad[k-1][SqW-1:SqW-2]};
    assign trial = {1'b0, s_root[k-1], 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_v[k] <= 1'b0;
      end else if (en) begin
        s_v[k] <= s_v[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        s_kind[k] <= s_kind[k-1];
        s_rad[k]  <= {s_rad[k-1][SqW-3:0], 2'b00};
        s_rem[k]  <= ge ? (cur - trial) : cur;
        s_root[k] <= {s_root[k-1][DistW-2:0], ge};
      end
    end
  end

  // result beat
  assign out_valid_o    = s_v[SqrtSteps];
  assign distance_o     = s_root[SqrtSteps];
  assign nearest_case_o = s_kind[SqrtSteps];

endmodule

`default_nettype wire
